/* src/i2cts_pkg.sv */
// Shared types and constants for the I2C master transaction sequencer.
// No dependencies; imported by every module of the block.
package i2cts_pkg;

	localparam int BYTE_W = 8;
	localparam int CNT_W  = 5;
	localparam int APB_AW = 3;

	typedef enum logic [2:0] {
		KIND_STATUS = 3'd0,
		KIND_START  = 3'd1,
		KIND_RESET  = 3'd2,
		KIND_BUF_WR = 3'd3,
		KIND_BUF_RD = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_STARTED   = 3'd1,
		PH_RESTARTED = 3'd2,
		PH_DATA_ACK  = 3'd3,
		PH_DONE      = 3'd4
	} phase_t;

	// bus controller status codes
	localparam logic [7:0] ST_BUS_ERR     = 8'h00;
	localparam logic [7:0] ST_START       = 8'h08;
	localparam logic [7:0] ST_RESTART     = 8'h10;
	localparam logic [7:0] ST_SLA_W_ACK   = 8'h18;
	localparam logic [7:0] ST_SLA_W_NACK  = 8'h20;
	localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
	localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
	localparam logic [7:0] ST_ARB_LOST    = 8'h38;
	localparam logic [7:0] ST_SLA_R_ACK   = 8'h40;
	localparam logic [7:0] ST_SLA_R_NACK  = 8'h48;
	localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
	localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

	// control set mask bits
	localparam logic [3:0] SET_ACK = 4'b0001;
	localparam logic [3:0] SET_STA = 4'b0010;
	localparam logic [3:0] SET_STO = 4'b0100;
	localparam logic [3:0] SET_EN  = 4'b1000;
	// control clear mask bits
	localparam logic [3:0] CLR_ACK = 4'b0001;
	localparam logic [3:0] CLR_SI  = 4'b0010;
	localparam logic [3:0] CLR_STA = 4'b0100;

	localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;

	// register index, taken from paddr[2]
	localparam logic REG_WRITE_LENGTH = 1'b0;
	localparam logic REG_READ_LENGTH  = 1'b1;

	typedef enum logic [1:0] {
		SRC_NONE   = 2'd0,
		SRC_MEM    = 2'd1,
		SRC_MEM_RD = 2'd2  // address byte with read bit set
	} send_src_t;

	typedef struct packed {
		send_src_t  send_src;
		logic       rdata_en;
		logic [3:0] cset;
		logic [3:0] cclr;
		phase_t     phase;
		logic       busy;
		logic       nack;
	} step_ctrl_t;

	typedef struct packed {
		logic [BYTE_W-1:0] slot_read_data;
		logic              nack_at_start;
		logic              busy_res;
		logic [2:0]        phase;
		logic [3:0]        control_clear;
		logic [3:0]        control_set;
		logic              send_load;
		logic [BYTE_W-1:0] send_byte;
	} result_t;

endpackage

/* src/i2cts_buf.sv */
// Byte store of the sequencer: one write port, one registered read port.
// Depends on i2cts_pkg.
module i2cts_buf #(
	parameter int BUFFER_DEPTH = 32
) (
	input  logic                               clk,
	input  logic                               we,
	input  logic [$clog2(BUFFER_DEPTH)-1:0]    waddr,
	input  logic [i2cts_pkg::BYTE_W-1:0]       wdata,
	input  logic                               re,
	input  logic [$clog2(BUFFER_DEPTH)-1:0]    raddr,
	output logic [i2cts_pkg::BYTE_W-1:0]       rdata_s1
);
	import i2cts_pkg::*;

	logic [BYTE_W-1:0] mem_q [BUFFER_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem_q[raddr];
		end
	end

endmodule

/* src/i2cts_ctrl.sv */
// Status decode and transaction state (phase, indices, busy, nack).
// Drives the byte store ports. Depends on i2cts_pkg.
module i2cts_ctrl #(
	parameter int BUFFER_DEPTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               accept,
	input  logic [2:0]                         kind,
	input  logic [i2cts_pkg::BYTE_W-1:0]       status_code,
	input  logic [i2cts_pkg::BYTE_W-1:0]       received_byte,
	input  logic [i2cts_pkg::CNT_W-1:0]        slot_index,
	input  logic [i2cts_pkg::BYTE_W-1:0]       slot_byte,
	input  logic [i2cts_pkg::CNT_W-1:0]        write_length,
	input  logic [i2cts_pkg::CNT_W-1:0]        read_length,
	output logic                               mem_we,
	output logic [$clog2(BUFFER_DEPTH)-1:0]    mem_waddr,
	output logic [i2cts_pkg::BYTE_W-1:0]       mem_wdata,
	output logic [$clog2(BUFFER_DEPTH)-1:0]    mem_raddr,
	output i2cts_pkg::step_ctrl_t              ctrl_next
);
	import i2cts_pkg::*;

	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int CW = (AW + 1 > 6) ? AW + 1 : 6;
	localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);

	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] wc_q, wc_d, rc_q, rc_d, rc_bump;
	logic             busy_q, busy_d, nack_q, nack_d;
	logic [CW-1:0]    wr_slot, rd_slot, slot_ext;
	logic             can_send, rx_fits, slot_ok, we;

	assign wr_slot  = CW'(wc_q) + CW'(1);
	assign rd_slot  = CW'(rc_q) + CW'(3);
	assign slot_ext = CW'(slot_index);
	assign slot_ok  = slot_ext < DEPTH_C;
	assign can_send = (wc_q < write_length) && (wc_q != COUNT_MAX) && (wr_slot < DEPTH_C);
	assign rx_fits  = rd_slot < DEPTH_C;
	// read index saturates at the store end and at the counter top
	assign rc_bump  = (rx_fits && rc_q != COUNT_MAX) ? rc_q + CNT_W'(1) : rc_q;

	always_comb begin
		phase_d   = phase_q;
		wc_d      = wc_q;
		rc_d      = rc_q;
		busy_d    = busy_q;
		nack_d    = nack_q;
		we        = 1'b0;
		mem_waddr = slot_ext[AW-1:0];
		mem_wdata = slot_byte;
		mem_raddr = wr_slot[AW-1:0];
		ctrl_next = '{send_src: SRC_NONE, rdata_en: 1'b0, cset: 4'b0, cclr: 4'b0,
			phase: PH_IDLE, busy: 1'b0, nack: 1'b0};

		unique case (kind)
			KIND_STATUS: begin
				unique case (status_code)
					ST_BUS_ERR, ST_DATA_W_NACK: begin
						ctrl_next.cset = SET_ACK | SET_STO;
						ctrl_next.cclr = CLR_SI;
						phase_d        = PH_DONE;
					end
					ST_START: begin
						mem_raddr          = '0;
						ctrl_next.send_src = SRC_MEM;
						ctrl_next.cset     = SET_ACK;
						ctrl_next.cclr     = CLR_SI | CLR_STA;
						phase_d            = PH_STARTED;
					end
					ST_RESTART: begin
						mem_raddr          = '0;
						ctrl_next.send_src = SRC_MEM_RD;
						ctrl_next.cset     = SET_ACK;
						ctrl_next.cclr     = CLR_SI | CLR_STA;
						phase_d            = PH_RESTARTED;
					end
					ST_SLA_W_ACK: begin
						if (phase_q == PH_STARTED) begin
							if (can_send) begin
								ctrl_next.send_src = SRC_MEM;
								wc_d               = wc_q + CNT_W'(1);
							end
							phase_d = PH_DATA_ACK;
						end
						ctrl_next.cset = SET_ACK;
						ctrl_next.cclr = CLR_SI;
					end
					ST_SLA_W_NACK: begin
						phase_d        = PH_DONE;
						ctrl_next.cset = SET_ACK | SET_STO;
						ctrl_next.cclr = CLR_SI;
						nack_d         = 1'b1;
					end
					ST_DATA_W_ACK: begin
						if (can_send) begin
							ctrl_next.send_src = SRC_MEM;
							wc_d               = wc_q + CNT_W'(1);
							phase_d            = PH_DATA_ACK;
							ctrl_next.cset     = SET_ACK;
						end else begin
							phase_d        = PH_DONE;
							ctrl_next.cset = SET_ACK | SET_STO;
						end
						ctrl_next.cclr = CLR_SI;
					end
					ST_ARB_LOST: begin
						ctrl_next.cset = SET_ACK | SET_STA;
						ctrl_next.cclr = CLR_SI;
					end
					ST_SLA_R_ACK: begin
						if (read_length > CNT_W'(1)) begin
							ctrl_next.cset = SET_ACK;
							ctrl_next.cclr = CLR_SI;
						end else begin
							ctrl_next.cclr = CLR_SI | CLR_ACK;
						end
					end
					ST_SLA_R_NACK: begin
						// phase stays; stop is requested with ack set and SI cleared
						ctrl_next.cset = SET_ACK | SET_STO;
						ctrl_next.cclr = CLR_SI;
					end
					ST_DATA_R_ACK: begin
						we        = rx_fits;
						mem_waddr = rd_slot[AW-1:0];
						mem_wdata = received_byte;
						rc_d      = rc_bump;
						if (CW'(rc_bump) + CW'(1) < CW'(read_length)) begin
							ctrl_next.cset = SET_ACK;
							ctrl_next.cclr = CLR_SI;
						end else begin
							ctrl_next.cclr = CLR_SI | CLR_ACK;
						end
					end
					ST_DATA_R_NACK: begin
						we             = rx_fits;
						mem_waddr      = rd_slot[AW-1:0];
						mem_wdata      = received_byte;
						phase_d        = PH_DONE;
						ctrl_next.cset = SET_ACK | SET_STO;
						ctrl_next.cclr = CLR_SI;
					end
					default: begin
						ctrl_next.cclr = CLR_SI;
					end
				endcase
				if (phase_d == PH_DONE) begin
					busy_d = 1'b0;
				end
			end
			KIND_START: begin
				ctrl_next.cclr = CLR_ACK | CLR_SI | CLR_STA;
				ctrl_next.cset = busy_q ? (SET_STA | SET_EN | SET_STO) : (SET_STA | SET_EN);
				busy_d  = 1'b1;
				rc_d    = '0;
				wc_d    = '0;
				nack_d  = 1'b0;
				phase_d = PH_IDLE;
			end
			KIND_RESET: begin
				ctrl_next.cset = SET_STO | SET_EN;
				ctrl_next.cclr = CLR_SI;
				busy_d  = 1'b0;
				rc_d    = '0;
				wc_d    = '0;
				phase_d = PH_IDLE;
			end
			KIND_BUF_WR: begin
				we = slot_ok;
			end
			KIND_BUF_RD: begin
				mem_raddr          = slot_ext[AW-1:0];
				ctrl_next.rdata_en = slot_ok;
			end
			default: begin
			end
		endcase

		ctrl_next.phase = phase_d;
		ctrl_next.busy  = busy_d;
		ctrl_next.nack  = nack_d;
	end

	assign mem_we = accept && we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			wc_q    <= '0;
			rc_q    <= '0;
			busy_q  <= 1'b0;
			nack_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			wc_q    <= wc_d;
			rc_q    <= rc_d;
			busy_q  <= busy_d;
			nack_q  <= nack_d;
		end
	end

endmodule

/* src/i2cts_out.sv */
// Stage 1 control register, result assembly and output register with handshake.
// Depends on i2cts_pkg.
module i2cts_out (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	output logic                          in_ready,
	input  i2cts_pkg::step_ctrl_t         ctrl_next,
	input  logic [i2cts_pkg::BYTE_W-1:0]  rdata_s1,
	output logic                          out_valid,
	input  logic                          out_ready,
	output i2cts_pkg::result_t            result_q
);
	import i2cts_pkg::*;

	step_ctrl_t ctrl_s1;
	logic       valid_s1, valid_q, advance;
	result_t    result_d;

	assign advance   = !valid_q || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = valid_q;

	always_comb begin
		unique case (ctrl_s1.send_src)
			SRC_MEM:    result_d.send_byte = rdata_s1;
			SRC_MEM_RD: result_d.send_byte = rdata_s1 | BYTE_W'(1);
			default:    result_d.send_byte = '0;
		endcase
		result_d.send_load      = ctrl_s1.send_src != SRC_NONE;
		result_d.control_set    = ctrl_s1.cset;
		result_d.control_clear  = ctrl_s1.cclr;
		result_d.phase          = ctrl_s1.phase;
		result_d.busy_res       = ctrl_s1.busy;
		result_d.nack_at_start  = ctrl_s1.nack;
		result_d.slot_read_data = ctrl_s1.rdata_en ? rdata_s1 : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctrl_s1 <= ctrl_next;
		end
		if (advance && valid_s1) begin
			result_q <= result_d;
		end
	end

endmodule

/* src/i2c_master_transaction_sequencer.sv */
// Top level of the I2C master transaction sequencer: stream ports, APB registers.
// Depends on i2cts_pkg, i2cts_ctrl, i2cts_buf, i2cts_out.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------
//  s_*      | in        | s_tvalid / s_tready    | s_tuser kind, s_tdata fields
//  m_*      | out       | m_tvalid / m_tready    | m_tdata result fields
//  apb      | in        | psel, penable, pwrite  | write_length, read_length
//
// One transaction per cycle sustained while m_tready is high. Decode and state
// update happen at the accept edge, the byte store read lands in stage 1, and
// the result register loads from stage 1 when it is empty or m_tready is high,
// which raises m_tvalid. s_tready drops only when stage 1 and the result
// register are both full and m_tready is low. Reset clears phase, indices,
// flags and both lengths; the byte store is not cleared.
module i2c_master_transaction_sequencer #(
	parameter int BUFFER_DEPTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [7:0] status_code, [15:8] received_byte, [20:16] slot_index, [28:21] slot_byte
	input  logic [31:0]                   s_tdata,
	// [2:0] kind
	input  logic [2:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [7:0] send_byte, [8] send_load, [12:9] control_set, [16:13] control_clear,
	// [19:17] phase, [20] busy_res, [21] nack_at_start, [29:22] slot_read_data
	output logic [31:0]                   m_tdata,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [i2cts_pkg::APB_AW-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import i2cts_pkg::*;

	localparam int AW = $clog2(BUFFER_DEPTH);

	logic [CNT_W-1:0]  write_length_q, read_length_q;
	logic              accept, cfg_we;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [BYTE_W-1:0] mem_wdata, rdata_s1;
	step_ctrl_t        ctrl_next;
	result_t           result_q;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_READ_LENGTH) ? 32'(read_length_q) : 32'(write_length_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_length_q <= '0;
			read_length_q  <= '0;
		end else if (cfg_we) begin
			if (paddr[2] == REG_WRITE_LENGTH) begin
				write_length_q <= pwdata[CNT_W-1:0];
			end else begin
				read_length_q <= pwdata[CNT_W-1:0];
			end
		end
	end

	assign accept = s_tvalid && s_tready;

	i2cts_ctrl #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.kind          (s_tuser),
		.status_code   (s_tdata[7:0]),
		.received_byte (s_tdata[15:8]),
		.slot_index    (s_tdata[20:16]),
		.slot_byte     (s_tdata[28:21]),
		.write_length  (write_length_q),
		.read_length   (read_length_q),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata),
		.mem_raddr     (mem_raddr),
		.ctrl_next     (ctrl_next)
	);

	i2cts_buf #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_buf (
		.clk      (clk),
		.we       (mem_we),
		.waddr    (mem_waddr),
		.wdata    (mem_wdata),
		.re       (accept),
		.raddr    (mem_raddr),
		.rdata_s1 (rdata_s1)
	);

	i2cts_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_ready  (s_tready),
		.ctrl_next (ctrl_next),
		.rdata_s1  (rdata_s1),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.result_q  (result_q)
	);

	assign m_tdata = {2'b00, result_q};

endmodule

/* src/i2cts_chk.sv */
// Port-level checker for the I2C master transaction sequencer, bound to the top.
// Depends on i2cts_pkg and i2c_master_transaction_sequencer.
module i2cts_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [31:0]                   m_tdata
);
	import i2cts_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// input side only backs up when the output side is stalled
	a_back_pressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output stall");

	// no byte is shown unless it is to be loaded
	a_send_load: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[8] |-> m_tdata[7:0] == 8'h00)
		else $error("send_byte set without send_load");

	// a finished transaction is never busy
	a_busy_phase: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[20] |-> m_tdata[19:17] != PH_DONE)
		else $error("busy in finished phase");

endmodule

bind i2c_master_transaction_sequencer i2cts_chk u_chk (.*);
